// File: rtl/vtpd_pkg.sv
`default_nettype none
package vtpd_pkg;

    // number format
    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int FIELD_W     = 32;

    // wide internal widths
    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int SUM_W  = 2 * COORD_WIDTH - FRAC_BITS + 2;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int QW     = COORD_WIDTH + 1;

    // configuration registers
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 4;

    // pipeline: input, product, sum, divide setup, QW divide steps, output
    localparam int NS = QW + 5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic        [REG_W-1:0]       coef_reg_t;

    typedef struct packed {
        logic   zero;
        coord_t quo;
        coord_t undiv;
    } div_res_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam coef_reg_t COEF_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    // product reduced by the fraction bits, truncating toward zero
    function automatic sum_t reduce_prod(input prod_t p);
        prod_t b;
        b = p + (p[PROD_W-1] ? prod_t'((prod_t'(1) <<< FRAC_BITS) - 1) : prod_t'(0));
        return sum_t'(b >>> FRAC_BITS);
    endfunction

    // clamp a wide sum to the coordinate range
    function automatic coord_t sat_sum(input sum_t s);
        coord_t r;
        if (s > sum_t'(COORD_MAX))
            r = COORD_MAX;
        else if (s < sum_t'(COORD_MIN))
            r = COORD_MIN;
        else
            r = coord_t'(s);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/vtpd_in_if.sv
`default_nettype none
interface vtpd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// File: rtl/vtpd_out_if.sv
`default_nettype none
interface vtpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

// File: rtl/vtpd_cfg_if.sv
`default_nettype none
interface vtpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/vtpd_col_lane.sv
`default_nettype none
module vtpd_col_lane
    import vtpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [1:0] en,
    input  wire coord_t     px,
    input  wire coord_t     py,
    input  wire coord_t     pz,
    input  wire coord_t     c0,
    input  wire coord_t     c1,
    input  wire coord_t     c2,
    input  wire coord_t     ct,
    output sum_t            sum
);

    prod_t  p0_reg, p1_reg, p2_reg;
    coord_t ct_reg;
    sum_t   sum_reg;

    // products, one multiplier per term
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg <= prod_t'(px) * prod_t'(c0);
            p1_reg <= prod_t'(py) * prod_t'(c1);
            p2_reg <= prod_t'(pz) * prod_t'(c2);
            ct_reg <= ct;
        end
    end

    // reduce and add the translation term
    always_ff @(posedge clk)
    begin
        if (en[1])
            sum_reg <= reduce_prod(p0_reg) + reduce_prod(p1_reg) + reduce_prod(p2_reg)
                     + sum_t'(ct_reg);
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

// File: rtl/vtpd_div_lane.sv
`default_nettype none
module vtpd_div_lane
    import vtpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [QW:0] en,
    input  wire sum_t        num,
    input  wire sum_t        den,
    output div_res_t         res
);

    localparam logic [QW-1:0] Q_LIM = QW'(1) << (COORD_WIDTH - 1);

    logic [SUM_W-1:0] r_reg    [QW+1];
    logic [QW-1:0]    qr_reg   [QW+1];
    logic [SUM_W-1:0] ud_reg   [QW+1];
    logic             neg_reg  [QW+1];
    logic             zero_reg [QW+1];
    logic             over_reg [QW+1];
    coord_t           undiv_reg[QW+1];

    logic [SUM_W-1:0] un, ud;
    logic [NUM_W-1:0] wide_num, hi;
    logic             over;

    // setup: magnitudes, early overflow test on the high quotient bits
    always_comb
    begin
        un       = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
        ud       = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
        wide_num = NUM_W'(un) << FRAC_BITS;
        hi       = wide_num >> QW;
        over     = hi >= NUM_W'(ud);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]     <= hi[SUM_W-1:0];
            qr_reg[0]    <= wide_num[QW-1:0];
            ud_reg[0]    <= ud;
            neg_reg[0]   <= num[SUM_W-1] ^ den[SUM_W-1];
            zero_reg[0]  <= (den == '0);
            over_reg[0]  <= over;
            undiv_reg[0] <= sat_sum(num);
        end
    end

    // one restoring step per stage
    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [SUM_W-1:0] t;
        logic             ge;

        always_comb
        begin
            t  = {r_reg[k-1][SUM_W-2:0], qr_reg[k-1][QW-1]};
            ge = t >= ud_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                r_reg[k]     <= ge ? t - ud_reg[k-1] : t;
                qr_reg[k]    <= {qr_reg[k-1][QW-2:0], ge};
                ud_reg[k]    <= ud_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                zero_reg[k]  <= zero_reg[k-1];
                over_reg[k]  <= over_reg[k-1];
                undiv_reg[k] <= undiv_reg[k-1];
            end
        end
    end

    // clamp, apply sign, saturate
    logic [QW-1:0]        mag;
    logic signed [QW:0]   sv;

    always_comb
    begin
        mag = (over_reg[QW] || (qr_reg[QW] > Q_LIM)) ? Q_LIM : qr_reg[QW];
        sv  = neg_reg[QW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        res.zero  = zero_reg[QW];
        res.undiv = undiv_reg[QW];
        res.quo   = (!neg_reg[QW] && (mag >= Q_LIM)) ? COORD_MAX : coord_t'(sv);
    end

endmodule
`default_nettype wire

// File: rtl/vertex_transform_perspective_divide.sv
`default_nettype none
// Vertex transform with perspective divide.
// pt_in carries one point (pos_x, pos_y, pos_z) per transaction; pt_out
// carries the transformed point (out_x, out_y, out_z); cfg writes one of
// the eight 64-bit coefficient registers, each holding two matrix entries.
// cfg is always ready and should only be written while no point is in flight.
// Four column lanes each form one dot product (x', y', z', w) in two stages,
// then three divider lanes divide x', y', z' by w with a pipelined restoring
// divider of one quotient bit per stage.
// Stages: input register, column stages, divide setup, divide steps, output.
// Throughput is one point per cycle while the receiver keeps pt_out.ready high.
// Each pipeline stage holds its item until the next stage is free, so bubbles
// close up and input is still taken while a result waits at the output; when
// the receiver stalls long enough the stall backs up to pt_in.ready.
// Reset clears all stage valid flags and loads the identity matrix.
module vertex_transform_perspective_divide
    import vtpd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vtpd_in_if.sink     pt_in,
    vtpd_out_if.source  pt_out,
    vtpd_cfg_if.sink    cfg
);

    coef_reg_t coef_reg [NUM_REGS];
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // coefficient registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= COEF_RESET;
        else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_REGS)))
            coef_reg[cfg.index[2:0]] <= cfg.data;
    end

    // stage enables, each stage moves when the next one is free
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || pt_out.ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= pt_in.valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    assign pt_in.ready = en[0];

    // input register
    coord_t px_reg, py_reg, pz_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= coord_t'(pt_in.pos_x[COORD_WIDTH-1:0]);
            py_reg <= coord_t'(pt_in.pos_y[COORD_WIDTH-1:0]);
            pz_reg <= coord_t'(pt_in.pos_z[COORD_WIDTH-1:0]);
        end
    end

    // matrix entries from register halves
    coord_t coef_m [4][4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            coef_m[r][0] = coord_t'(coef_reg[2*r][COORD_WIDTH-1:0]);
            coef_m[r][1] = coord_t'(coef_reg[2*r][32+COORD_WIDTH-1:32]);
            coef_m[r][2] = coord_t'(coef_reg[2*r+1][COORD_WIDTH-1:0]);
            coef_m[r][3] = coord_t'(coef_reg[2*r+1][32+COORD_WIDTH-1:32]);
        end
    end

    // column lanes
    sum_t col_sum [4];

    for (genvar c = 0; c < 4; c++)
    begin : g_col
        vtpd_col_lane u_col (
            .clk (clk),
            .en  (en[2:1]),
            .px  (px_reg),
            .py  (py_reg),
            .pz  (pz_reg),
            .c0  (coef_m[0][c]),
            .c1  (coef_m[1][c]),
            .c2  (coef_m[2][c]),
            .ct  (coef_m[3][c]),
            .sum (col_sum[c])
        );
    end

    // divider lanes
    div_res_t div_res [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        vtpd_div_lane u_div (
            .clk (clk),
            .en  (en[QW+3:3]),
            .num (col_sum[k]),
            .den (col_sum[3]),
            .res (div_res[k])
        );
    end

    // merge: pick undivided result when w is zero
    coord_t out_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
            for (int k = 0; k < 3; k++)
                out_reg[k] <= div_res[k].zero ? div_res[k].undiv : div_res[k].quo;
    end

    assign pt_out.valid = v_reg[NS-1];
    assign pt_out.out_x = FIELD_W'(out_reg[0]);
    assign pt_out.out_y = FIELD_W'(out_reg[1]);
    assign pt_out.out_z = FIELD_W'(out_reg[2]);

    // a free output lets the whole pipe move
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_out.ready || !pt_out.valid) |-> pt_in.ready)
        else $error("input stalled with a free output stage");

    // a result appears only from an item in flight
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pt_out.valid) |-> $past(v_reg[NS-2]))
        else $error("result valid without an item in the pipe");

endmodule
`default_nettype wire
